// ===== src/occupancy_grid_table_update_core_assert.svh =====
`ifndef OCCUPANCY_GRID_TABLE_UPDATE_CORE_ASSERT_SVH
`define OCCUPANCY_GRID_TABLE_UPDATE_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define OGTU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define OGTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ogtu_pkg.sv =====
package ogtu_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;
    localparam int NUM_TABLES_DEF  = 2;

    localparam int CELL_W     = 16;
    localparam int TABLE_AW   = 15;
    localparam int COORD_W    = 8;
    localparam int PENDING_W  = 17;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;

    localparam logic [CELL_W-1:0] UPDATE_MARKER = 16'h8000;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_APPLY  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic en;
        logic we;
    } t_cell_ctl;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_tab_ctl;

    typedef struct packed {
        logic push;
        logic clear;
        logic rd;
    } t_list_ctl;

endpackage

// ===== src/ogtu_cells.sv =====
module ogtu_cells #(
    parameter int GRID_WIDTH  = ogtu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogtu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  ogtu_pkg::t_cell_ctl                      i_ctl,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] i_addr,
    input  logic [ogtu_pkg::CELL_W-1:0]              i_wdata,
    output logic [ogtu_pkg::CELL_W-1:0]              o_rdata,
    output logic                                     o_ready
);
    import ogtu_pkg::*;

    localparam int CellCount = GRID_WIDTH * GRID_HEIGHT;
    localparam int CellAw    = $clog2(CellCount);

    logic [CELL_W-1:0] r_mem [CellCount];
    logic [CELL_W-1:0] r_rdata;
    logic [CellAw-1:0] r_clr_addr;
    logic              r_clr_done;

    // sweep the whole grid to the unknown value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == CellAw'(CellCount - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.en && i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && !i_ctl.we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = r_clr_done;

endmodule

// ===== src/ogtu_tables.sv =====
module ogtu_tables #(
    parameter int NUM_TABLES = ogtu_pkg::NUM_TABLES_DEF
) (
    input  logic                          i_clk,
    input  ogtu_pkg::t_tab_ctl            i_ctl,
    input  logic                          i_wr_sel,
    input  logic [ogtu_pkg::TABLE_AW-1:0] i_wr_addr,
    input  logic [ogtu_pkg::CELL_W-1:0]   i_wr_data,
    input  logic                          i_rd_sel,
    input  logic [ogtu_pkg::TABLE_AW-1:0] i_rd_addr,
    output logic [ogtu_pkg::CELL_W-1:0]   o_rdata
);
    import ogtu_pkg::*;

    localparam int TabAw    = $clog2(NUM_TABLES) + TABLE_AW;
    localparam int TabDepth = NUM_TABLES << TABLE_AW;

    logic [CELL_W-1:0] r_mem [TabDepth];
    logic [CELL_W-1:0] r_rdata;
    logic              wr_hit;
    logic [TabAw-1:0]  wr_flat;
    logic [TabAw-1:0]  rd_flat;

    // drop loads aimed at a table that does not exist
    assign wr_hit  = i_ctl.wr && (32'(i_wr_sel) < NUM_TABLES);
    assign wr_flat = TabAw'({i_wr_sel, i_wr_addr});
    assign rd_flat = TabAw'({i_rd_sel, i_rd_addr});

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_flat] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[rd_flat];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ogtu_touch.sv =====
module ogtu_touch #(
    parameter int GRID_WIDTH  = ogtu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogtu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  ogtu_pkg::t_list_ctl                        i_ctl,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   i_wdata,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   i_rd_addr,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   o_rdata,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT+1)-1:0] o_count,
    output logic                                       o_full
);
    import ogtu_pkg::*;

    localparam int CellCount = GRID_WIDTH * GRID_HEIGHT;
    localparam int CellAw    = $clog2(CellCount);
    localparam int CntW      = $clog2(CellCount + 1);

    logic [CellAw-1:0] r_mem [CellCount];
    logic [CellAw-1:0] r_rdata;
    logic [CntW-1:0]   r_count;
    logic              full;

    assign full = (r_count == CntW'(CellCount));

    // append at the fill count, empty on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.push && !full) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !full) begin
            r_mem[CellAw'(r_count)] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;
    assign o_full  = full;

endmodule

// ===== src/occupancy_grid_table_update_core.sv =====
// Occupancy grid cell store updated through two loadable lookup tables.
// Input items arrive on s_axis: tuser carries the op and the table select,
// tdata carries table address/value and the cell coordinates. Every item
// yields exactly one result item on m_axis with the cell value, the applied
// flag, the known-cells box and the number of cells pending a finish.
// The cell memory has a single port, so the steps run in order: apply
// reads the cell, then the table, then writes the cell; finish reads the
// list entry, reads the cell and writes it back, entry by entry.
// A new item is taken the cycle after the previous result is loaded into
// the output register, even while that result still waits downstream.
// After reset the grid is swept to zero at one cell per cycle; s_axis_tready
// stays low until the sweep ends. The touched list empties and the box reads
// empty.
// When m_axis_tready is low, the result holds in the output register and the
// core waits with the next result until the register frees up.
`include "occupancy_grid_table_update_core_assert.svh"

module occupancy_grid_table_update_core #(
    parameter int GRID_WIDTH  = ogtu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogtu_pkg::GRID_HEIGHT_DEF,
    parameter int NUM_TABLES  = ogtu_pkg::NUM_TABLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // table_addr[14:0], table_value[30:15], cell_x[38:31], cell_y[46:39], pad
    input  logic [ogtu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0], table_select[2]
    input  logic [ogtu_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // applied[0], cell_value[16:1], box_empty[17], box_min_x[25:18],
    // box_min_y[33:26], box_max_x[41:34], box_max_y[49:42],
    // pending_count[66:50], pad
    output logic [ogtu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ogtu_pkg::*;

    localparam int CellCount = GRID_WIDTH * GRID_HEIGHT;
    localparam int CellAw    = $clog2(CellCount);
    localparam int CntW      = $clog2(CellCount + 1);

    localparam logic [2:0] S_IDLE = 3'd0;  // wait for an item
    localparam logic [2:0] S_LOOK = 3'd1;  // cell data back
    localparam logic [2:0] S_TAB  = 3'd2;  // table data back, write cell
    localparam logic [2:0] S_FC   = 3'd3;  // list entry back, read its cell
    localparam logic [2:0] S_FW   = 3'd4;  // cell back, strip the marker
    localparam logic [2:0] S_RESP = 3'd5;  // hand result to output register

    // input field split
    logic [1:0]          in_op;
    logic                in_sel;
    logic [TABLE_AW-1:0] in_addr;
    logic [CELL_W-1:0]   in_value;
    logic [COORD_W-1:0]  in_x;
    logic [COORD_W-1:0]  in_y;
    logic                in_inside;
    logic [CellAw-1:0]   in_flat;
    logic                in_fire;

    assign in_op     = s_axis_tuser[1:0];
    assign in_sel    = s_axis_tuser[2];
    assign in_addr   = s_axis_tdata[14:0];
    assign in_value  = s_axis_tdata[30:15];
    assign in_x      = s_axis_tdata[38:31];
    assign in_y      = s_axis_tdata[46:39];
    assign in_inside = (32'(in_x) < GRID_WIDTH) && (32'(in_y) < GRID_HEIGHT);
    assign in_flat   = in_inside ? CellAw'(32'(in_y) * 32'(GRID_WIDTH) + 32'(in_x)) : '0;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // registers and their next values
    logic [2:0]         r_state,     n_state;
    logic [1:0]         r_op,        n_op;
    logic               r_sel,       n_sel;
    logic               r_inside,    n_inside;
    logic [CellAw-1:0]  r_flat,      n_flat;
    logic [COORD_W-1:0] r_x,         n_x;
    logic [COORD_W-1:0] r_y,         n_y;
    logic [CellAw-1:0]  r_fi,        n_fi;
    logic [CellAw-1:0]  r_fidx,      n_fidx;
    logic               r_applied,   n_applied;
    logic [CELL_W-1:0]  r_value,     n_value;
    logic               r_box_empty, n_box_empty;
    logic [COORD_W-1:0] r_min_x,     n_min_x;
    logic [COORD_W-1:0] r_min_y,     n_min_y;
    logic [COORD_W-1:0] r_max_x,     n_max_x;
    logic [COORD_W-1:0] r_max_y,     n_max_y;
    logic               r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // memory side
    t_cell_ctl         cell_ctl;
    logic [CellAw-1:0] cell_addr;
    logic [CELL_W-1:0] cell_wdata;
    logic [CELL_W-1:0] cell_q;
    logic              cell_ready;
    t_tab_ctl          tab_ctl;
    logic [CELL_W-1:0] tab_q;
    t_list_ctl         list_ctl;
    logic [CellAw-1:0] list_rd_addr;
    logic [CellAw-1:0] list_q;
    logic [CntW-1:0]   list_count;
    logic              list_full;

    logic apply_ok;
    logic out_free;
    logic out_load;

    ogtu_cells #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_addr  (cell_addr),
        .i_wdata (cell_wdata),
        .o_rdata (cell_q),
        .o_ready (cell_ready)
    );

    ogtu_tables #(
        .NUM_TABLES (NUM_TABLES)
    ) u_tables (
        .i_clk     (i_clk),
        .i_ctl     (tab_ctl),
        .i_wr_sel  (in_sel),
        .i_wr_addr (in_addr),
        .i_wr_data (in_value),
        .i_rd_sel  (r_sel),
        .i_rd_addr (cell_q[TABLE_AW-1:0]),
        .o_rdata   (tab_q)
    );

    ogtu_touch #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_touch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (list_ctl),
        .i_wdata   (r_flat),
        .i_rd_addr (list_rd_addr),
        .o_rdata   (list_q),
        .o_count   (list_count),
        .o_full    (list_full)
    );

    // an apply goes ahead only on an unmarked cell inside the grid, with a
    // valid table and room left in the touched list
    assign apply_ok = r_inside && (cell_q < UPDATE_MARKER) &&
                      (32'(r_sel) < NUM_TABLES) && !list_full;

    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_RESP) && out_free;

    assign s_axis_tready = (r_state == S_IDLE) && cell_ready;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sel       = r_sel;
        n_inside    = r_inside;
        n_flat      = r_flat;
        n_x         = r_x;
        n_y         = r_y;
        n_fi        = r_fi;
        n_fidx      = r_fidx;
        n_applied   = r_applied;
        n_value     = r_value;
        n_box_empty = r_box_empty;
        n_min_x     = r_min_x;
        n_min_y     = r_min_y;
        n_max_x     = r_max_x;
        n_max_y     = r_max_y;

        cell_ctl     = '0;
        cell_addr    = r_flat;
        cell_wdata   = '0;
        tab_ctl      = '0;
        list_ctl     = '0;
        list_rd_addr = r_fi;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op      = in_op;
                    n_sel     = in_sel;
                    n_inside  = in_inside;
                    n_flat    = in_flat;
                    n_x       = in_x;
                    n_y       = in_y;
                    n_applied = 1'b0;
                    n_value   = '0;
                    case (in_op)
                        OP_LOAD: begin
                            tab_ctl.wr = 1'b1;
                            n_state    = S_RESP;
                        end
                        OP_APPLY, OP_READ: begin
                            // cell read for a cell inside the grid goes out on the accept edge
                            cell_ctl.en = in_inside;
                            cell_addr   = in_flat;
                            n_state     = S_LOOK;
                        end
                        OP_FINISH: begin
                            if (list_count == '0) begin
                                n_state = S_RESP;
                            end else begin
                                // walk the list from its last entry down
                                list_ctl.rd  = 1'b1;
                                list_rd_addr = CellAw'(list_count - 1'b1);
                                n_fi         = CellAw'(list_count - 1'b1);
                                n_state      = S_FC;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if ((r_op == OP_APPLY) && apply_ok) begin
                    tab_ctl.rd = 1'b1;
                    n_state    = S_TAB;
                end else begin
                    n_value = r_inside ? cell_q : '0;
                    n_state = S_RESP;
                end
            end
            S_TAB: begin
                cell_ctl.en   = 1'b1;
                cell_ctl.we   = 1'b1;
                cell_addr     = r_flat;
                cell_wdata    = tab_q;
                list_ctl.push = 1'b1;
                n_value       = tab_q;
                n_applied     = 1'b1;
                if (r_box_empty) begin
                    n_box_empty = 1'b0;
                    n_min_x     = r_x;
                    n_max_x     = r_x;
                    n_min_y     = r_y;
                    n_max_y     = r_y;
                end else begin
                    if (r_x < r_min_x) n_min_x = r_x;
                    if (r_x > r_max_x) n_max_x = r_x;
                    if (r_y < r_min_y) n_min_y = r_y;
                    if (r_y > r_max_y) n_max_y = r_y;
                end
                n_state = S_RESP;
            end
            S_FC: begin
                cell_ctl.en = 1'b1;
                cell_addr   = list_q;
                n_fidx      = list_q;
                n_state     = S_FW;
            end
            S_FW: begin
                // subtraction wraps on a cell that never got the marker
                cell_ctl.en = 1'b1;
                cell_ctl.we = 1'b1;
                cell_addr   = r_fidx;
                cell_wdata  = cell_q - UPDATE_MARKER;
                if (r_fi == '0) begin
                    list_ctl.clear = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    list_ctl.rd  = 1'b1;
                    list_rd_addr = r_fi - 1'b1;
                    n_fi         = r_fi - 1'b1;
                    n_state      = S_FC;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: box and count are live, so they show the state after the op
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {5'd0, PENDING_W'(list_count), r_max_y, r_max_x, r_min_y,
                           r_min_x, r_box_empty, r_value, r_applied};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box_empty <= 1'b1;
            r_min_x     <= '0;
            r_min_y     <= '0;
            r_max_x     <= '0;
            r_max_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_box_empty <= n_box_empty;
            r_min_x     <= n_min_x;
            r_min_y     <= n_min_y;
            r_max_x     <= n_max_x;
            r_max_y     <= n_max_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sel      <= n_sel;
        r_inside   <= n_inside;
        r_flat     <= n_flat;
        r_x        <= n_x;
        r_y        <= n_y;
        r_fi       <= n_fi;
        r_fidx     <= n_fidx;
        r_applied  <= n_applied;
        r_value    <= n_value;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `OGTU_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_fire, r_state != S_IDLE, "accepted item did not start work")
    `OGTU_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, list_ctl.push, !list_full, "touched list push while full")
    `OGTU_ASSERT_NOW(a_box_ordered, i_clk, i_rst_n, !r_box_empty, (r_min_x <= r_max_x) && (r_min_y <= r_max_y), "known box corners crossed")
    `OGTU_ASSERT_NEXT(a_finish_empties_list, i_clk, i_rst_n, list_ctl.clear, list_count == '0, "touched list not empty after finish")

endmodule

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ogtu_pkg::*;

    localparam int GRID_CELLS = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;
    localparam int LUT_DEPTH  = 1 << TABLE_AW;

    // One result item, field by field.
    typedef struct {
        logic                 applied;
        logic [CELL_W-1:0]    cell_value;
        logic                 box_empty;
        logic [COORD_W-1:0]   box_min_x;
        logic [COORD_W-1:0]   box_min_y;
        logic [COORD_W-1:0]   box_max_x;
        logic [COORD_W-1:0]   box_max_y;
        logic [PENDING_W-1:0] pending;
    } t_cell_report;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // table_addr[14:0], table_value[30:15], cell_x[38:31], cell_y[46:39], pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // op[1:0], table_select[2]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // applied[0], cell_value[16:1], box_empty[17], box_min_x[25:18],
    // box_min_y[33:26], box_max_x[41:34], box_max_y[49:42], pending_count[66:50]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the block's state, advanced once per accepted item.
    logic [CELL_W-1:0]  grid_mem [0:GRID_CELLS-1];
    logic [CELL_W-1:0]  lut_mem [0:1][0:LUT_DEPTH-1];
    bit                 lut_loaded [0:1][0:LUT_DEPTH-1];
    logic [15:0]        touched_cells [$];
    bit                 box_none = 1'b1;
    logic [COORD_W-1:0] bx_lo = '0, by_lo = '0, bx_hi = '0, by_hi = '0;

    t_cell_report reports_due [$];

    int          fail_count   = 0;
    int          items_sent   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;
    logic [7:0]  win_x        = '0;
    logic [7:0]  win_y        = '0;

    occupancy_grid_table_update_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Advance the shadow state by one item and return the result it must produce.
    function automatic t_cell_report predict_cell_op(input logic [1:0] op, input logic sel,
                                                     input logic [14:0] addr,
                                                     input logic [15:0] tval,
                                                     input logic [7:0] x, input logic [7:0] y);
        t_cell_report rep;
        logic [15:0]  flat;
        logic [15:0]  c;
        rep.applied    = 1'b0;
        rep.cell_value = '0;
        flat = {y, x};
        case (op)
            OP_LOAD: begin
                lut_mem[sel][addr]    = tval;
                lut_loaded[sel][addr] = 1'b1;
            end
            OP_APPLY: begin
                c = grid_mem[flat];
                // Refuse marked cells and a full touched list; report the cell as is.
                if (c < UPDATE_MARKER && touched_cells.size() < GRID_CELLS) begin
                    touched_cells = {touched_cells, flat};
                    c = lut_mem[sel][c[14:0]];
                    grid_mem[flat] = c;
                    if (box_none) begin
                        bx_lo = x; bx_hi = x; by_lo = y; by_hi = y;
                        box_none = 1'b0;
                    end else begin
                        if (x < bx_lo) bx_lo = x;
                        if (x > bx_hi) bx_hi = x;
                        if (y < by_lo) by_lo = y;
                        if (y > by_hi) by_hi = y;
                    end
                    rep.applied = 1'b1;
                end
                rep.cell_value = c;
            end
            OP_FINISH: begin
                // A cell listed twice loses the marker twice; wrap modulo 2^16.
                foreach (touched_cells[i])
                    grid_mem[touched_cells[i]] = grid_mem[touched_cells[i]] - UPDATE_MARKER;
                touched_cells.delete();
            end
            default: begin
                rep.cell_value = grid_mem[flat];
            end
        endcase
        rep.box_empty = box_none;
        rep.box_min_x = bx_lo;
        rep.box_min_y = by_lo;
        rep.box_max_x = bx_hi;
        rep.box_max_y = by_hi;
        rep.pending   = PENDING_W'(touched_cells.size());
        return rep;
    endfunction

    // Offer one item, hold it until accepted, then idle at random.
    task automatic send_item(input logic [1:0] op, input logic sel, input logic [14:0] addr,
                             input logic [15:0] tval, input logic [7:0] x,
                             input logic [7:0] y);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, op};
        s_axis_tdata  <= {1'b0, y, x, tval, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        reports_due = {reports_due, predict_cell_op(op, sel, addr, tval, x, y)};
        items_sent++;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    function automatic logic [15:0] pick_table_value();
        if ($urandom_range(0, 99) < 85)
            return UPDATE_MARKER | 16'($urandom);
        return 16'($urandom);
    endfunction

    // Apply with random don't-care fields. Load the table entry the cell will
    // index first if it was never written, so no undefined entry is read.
    task automatic send_apply(input logic sel, input logic [7:0] x, input logic [7:0] y);
        logic [15:0] c;
        c = grid_mem[{y, x}];
        if (c < UPDATE_MARKER && !lut_loaded[sel][c[14:0]])
            send_item(OP_LOAD, sel, c[14:0], pick_table_value(), 8'($urandom), 8'($urandom));
        send_item(OP_APPLY, sel, 15'($urandom), 16'($urandom), x, y);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y);
        send_item(op, 1'($urandom), 15'($urandom), 16'($urandom), x, y);
    endtask

    // Mostly a small window so cells repeat and get refused, sometimes anywhere.
    function automatic logic [15:0] pick_cell();
        if ($urandom_range(0, 99) < 60)
            return {win_y + 8'($urandom_range(0, 5)), win_x + 8'($urandom_range(0, 5))};
        return 16'($urandom);
    endfunction

    // Drop the offer and wait until every outstanding result is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: stall at random, or hold off entirely while rx_hold is set.
    always @(posedge i_clk) begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Compare every accepted result against the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_cell_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reports_due.size() == 0) begin
                $display("%0t ns: result with nothing outstanding, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("applied",    want.applied,    m_axis_tdata[0]);
                check_field("cell_value", want.cell_value, m_axis_tdata[16:1]);
                check_field("box_empty",  want.box_empty,  m_axis_tdata[17]);
                check_field("box_min_x",  want.box_min_x,  m_axis_tdata[25:18]);
                check_field("box_min_y",  want.box_min_y,  m_axis_tdata[33:26]);
                check_field("box_max_x",  want.box_max_x,  m_axis_tdata[41:34]);
                check_field("box_max_y",  want.box_max_y,  m_axis_tdata[49:42]);
                check_field("pending",    want.pending,    m_axis_tdata[66:50]);
            end
        end
    end

    // Corners of the grid, both tables, extreme table addresses and values,
    // refusal of a marked cell, a table value without the marker (finish
    // wraps) and a cell listed twice in one update.
    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(OP_LOAD, 1'b0, 15'd0,      16'h8005, 8'hff, 8'hff);
        send_item(OP_LOAD, 1'b1, 15'd0,      16'h1234, 8'h00, 8'h00);
        send_item(OP_LOAD, 1'b1, 15'h1234,   16'h1234, 8'h5a, 8'ha5);
        send_item(OP_LOAD, 1'b0, 15'd5,      16'hffff, 8'h00, 8'hff);
        send_item(OP_LOAD, 1'b0, 15'h7fff,   16'hffff, 8'hff, 8'h00);
        send_item(OP_LOAD, 1'b1, 15'h7fff,   16'h8000, 8'h12, 8'h34);
        send_apply(1'b0, 8'd0,   8'd0);
        send_apply(1'b0, 8'd0,   8'd0);
        send_apply(1'b0, 8'd255, 8'd255);
        send_apply(1'b1, 8'd0,   8'd255);
        send_apply(1'b1, 8'd255, 8'd0);
        send_apply(1'b1, 8'd255, 8'd0);
        send_op(OP_READ, 8'd0,   8'd0);
        send_op(OP_READ, 8'd128, 8'd77);
        send_op(OP_FINISH, 8'd0, 8'd0);
        send_op(OP_READ, 8'd0,   8'd0);
        send_op(OP_READ, 8'd0,   8'd255);
        send_op(OP_READ, 8'd255, 8'd0);
        send_apply(1'b0, 8'd0, 8'd0);
        send_op(OP_FINISH, 8'hff, 8'hff);
        send_apply(1'b0, 8'd0, 8'd0);
        send_op(OP_FINISH, 8'd0, 8'd0);
        send_op(OP_READ, 8'd0, 8'd0);
    endtask

    // Update rounds: loads, a burst of applies, reads, then finish; now and
    // then a stray single item instead.
    task automatic test_random_phase(input int n_items, input int tx_pct, input int rx_pct);
        int          start;
        logic [15:0] pos;
        logic [1:0]  op;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        win_x = 8'($urandom_range(0, 250));
        win_y = 8'($urandom_range(0, 250));
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                repeat ($urandom_range(0, 2))
                    send_item(OP_LOAD, 1'($urandom), 15'($urandom), pick_table_value(),
                              8'($urandom), 8'($urandom));
                repeat ($urandom_range(1, 12)) begin
                    pos = pick_cell();
                    send_apply(1'($urandom), pos[7:0], pos[15:8]);
                end
                repeat ($urandom_range(0, 3)) begin
                    pos = pick_cell();
                    send_op(OP_READ, pos[7:0], pos[15:8]);
                end
                send_op(OP_FINISH, 8'($urandom), 8'($urandom));
            end else begin
                op  = 2'($urandom);
                pos = pick_cell();
                case (op)
                    OP_LOAD:  send_item(OP_LOAD, 1'($urandom), 15'($urandom),
                                        pick_table_value(), pos[7:0], pos[15:8]);
                    OP_APPLY: send_apply(1'($urandom), pos[7:0], pos[15:8]);
                    default:  send_op(op, pos[7:0], pos[15:8]);
                endcase
            end
        end
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so
    // the output register fills and the input stalls; then drain fully.
    task automatic test_backpressure();
        logic [15:0] pos;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (24) begin
            pos = pick_cell();
            if ($urandom_range(0, 1) == 0)
                send_apply(1'($urandom), pos[7:0], pos[15:8]);
            else
                send_op(OP_READ, pos[7:0], pos[15:8]);
        end
        send_op(OP_FINISH, 8'($urandom), 8'($urandom));
        wait_drained();
    endtask

    initial begin
        foreach (grid_mem[i]) grid_mem[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block sweeps its grid after reset; send_item waits it out.
        test_directed();
        wait_drained();
        test_random_phase(120, 0, 0);
        test_random_phase(120, 72, 0);
        test_random_phase(120, 0, 72);
        test_backpressure();
        test_random_phase(120, 18, 18);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("occupancy_grid_table_update_core verification clean");
        else
            $display("occupancy_grid_table_update_core verification failed");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this.
    initial begin
        #20_000_000;
        $display("occupancy_grid_table_update_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
